@@ hdl/ar_pkg.sv @@
`timescale 1ns / 1ps

package ar_pkg;

   localparam int WIN_LEN    = 1024;
   localparam int WORD_BITS  = 64;
   localparam int SEQ_BITS   = 64;
   localparam int LIMIT_BITS = 32;
   localparam int WIN_WORDS  = (WIN_LEN + WORD_BITS - 1) / WORD_BITS;
   localparam int IDX_W      = (WIN_WORDS > 1) ? $clog2(WIN_WORDS) : 1;
   localparam int PTR_W      = IDX_W + 1;
   localparam int WORD_SHIFT = $clog2(WORD_BITS);
   localparam int TOP_WORD   = (WIN_LEN - 1) / WORD_BITS;
   localparam int TOP_BIT    = (WIN_LEN - 1) % WORD_BITS;

   localparam logic [WORD_BITS-1:0]  TOP_MASK    = {{(WORD_BITS-1){1'b0}}, 1'b1} << TOP_BIT;
   localparam logic [LIMIT_BITS-1:0] AHEAD_RESET = LIMIT_BITS'(1024);

   localparam logic OP_TEST = 1'b0;
   localparam logic OP_ADD  = 1'b1;

   typedef struct packed {
      logic                 rd_en;
      logic [PTR_W-1:0]     rd_ptr;
      logic                 wr_en;
      logic [IDX_W-1:0]     wr_addr;
      logic [WORD_BITS-1:0] wr_data;
      logic                 clr_all;
   } mem_req_type;

   typedef struct packed {
      logic done;
      logic is_replay;
   } result_type;

endpackage

@@ hdl/ar_bitmap_mem.sv @@
`timescale 1ns / 1ps

module ar_bitmap_mem
   import ar_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  mem_req_type          mem_req,
   output logic [WORD_BITS-1:0] rd_word
);

   logic [WORD_BITS-1:0] mem [WIN_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [WIN_WORDS-1:0] valid_ff, valid_in;
   logic                 hit_ff, hit_in;
   logic [IDX_W-1:0]     rd_idx;
   logic                 rd_in_range;

   assign rd_idx      = mem_req.rd_ptr[IDX_W-1:0];
   assign rd_in_range = mem_req.rd_ptr < PTR_W'(WIN_WORDS);

   // A word that has not been written since reset or the last clear reads as zero,
   // as does any pointer beyond the top of the window.
   assign hit_in  = mem_req.rd_en && rd_in_range && valid_ff[rd_idx];
   assign rd_word = hit_ff ? rd_data_ff : '0;

   always_comb begin
      valid_in = valid_ff;
      if (mem_req.clr_all) begin
         valid_in = '0;
      end
      if (mem_req.wr_en) begin
         valid_in[mem_req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_out_of_range_zero : assert property (@(posedge clock) disable iff (reset)
      $past(mem_req.rd_en && !rd_in_range) |-> rd_word == '0)
      else $error("read beyond the window did not return zero");
`endif

endmodule

@@ hdl/ar_seq_ctrl.sv @@
`timescale 1ns / 1ps

module ar_seq_ctrl
   import ar_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_opcode,
   input  logic [SEQ_BITS-1:0]   req_seq_num,
   input  logic [LIMIT_BITS-1:0] ahead_limit,
   input  logic                  out_free,
   output result_type            result,
   output mem_req_type           mem_req,
   input  logic [WORD_BITS-1:0]  rd_word
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_LOOK,
      S_PREP,
      S_LOAD,
      S_SHIFT,
      S_DONE
   } state_type;

   state_type                   state_ff, state_in;
   logic                        op_ff, op_in;
   logic [SEQ_BITS-1:0]         seq_ff, seq_in;
   logic [SEQ_BITS-1:0]         off_ff, off_in;
   logic [SEQ_BITS-1:0]         base_ff, base_in;
   logic [SEQ_BITS-1:0]         adv_ff, adv_in;
   logic                        replay_ff, replay_in;
   logic [WORD_BITS-1:0]        lo_ff, lo_in;
   logic [WORD_SHIFT-1:0]       shamt_ff, shamt_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [PTR_W-1:0]            rptr_ff, rptr_in;

   logic [IDX_W-1:0]            word_idx;
   logic [WORD_SHIFT-1:0]       bit_idx;
   logic [IDX_W-1:0]            adv_word;
   logic                        in_win;
   logic                        too_far;
   logic [2*WORD_BITS-1:0]      pair;
   logic [WORD_BITS-1:0]        shifted;
   logic [PTR_W-1:0]            rptr_next;

   assign word_idx = off_ff[WORD_SHIFT +: IDX_W];
   assign bit_idx  = off_ff[WORD_SHIFT-1:0];
   assign adv_word = adv_ff[WORD_SHIFT +: IDX_W];
   assign in_win   = off_ff < SEQ_BITS'(WIN_LEN);
   assign too_far  = {1'b0, off_ff} >= ((SEQ_BITS+1)'(WIN_LEN) + (SEQ_BITS+1)'(ahead_limit));

   // Each new word takes its low part from the word held back and its high part
   // from the word just read, so the pass needs only one read per cycle.
   assign pair    = {rd_word, lo_ff} >> shamt_ff;
   assign shifted = pair[WORD_BITS-1:0];

   assign rptr_next = (rptr_ff < PTR_W'(WIN_WORDS)) ? rptr_ff + PTR_W'(1) : rptr_ff;

   assign req_ready        = state_ff == S_IDLE;
   assign result.done      = (state_ff == S_DONE) && out_free;
   assign result.is_replay = replay_ff;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      seq_in    = seq_ff;
      off_in    = off_ff;
      base_in   = base_ff;
      adv_in    = adv_ff;
      replay_in = replay_ff;
      lo_in     = lo_ff;
      shamt_in  = shamt_ff;
      idx_in    = idx_ff;
      rptr_in   = rptr_ff;
      mem_req   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_opcode;
               seq_in    = req_seq_num;
               off_in    = req_seq_num - base_ff;
               replay_in = 1'b0;
               state_in  = S_EVAL;
            end
         end
         S_EVAL: begin
            if (in_win) begin
               mem_req.rd_en  = 1'b1;
               mem_req.rd_ptr = {1'b0, word_idx};
               state_in       = S_LOOK;
            end else if (op_ff == OP_TEST) begin
               replay_in = too_far;
               state_in  = S_DONE;
            end else begin
               // The new base puts the recorded number on the top bit of the window.
               adv_in   = off_ff - SEQ_BITS'(WIN_LEN - 1);
               base_in  = seq_ff - SEQ_BITS'(WIN_LEN - 1);
               state_in = S_PREP;
            end
         end
         S_LOOK: begin
            if (op_ff == OP_TEST) begin
               replay_in = rd_word[bit_idx];
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = word_idx;
               mem_req.wr_data = rd_word | (WORD_BITS'(1) << bit_idx);
            end
            state_in = S_DONE;
         end
         S_PREP: begin
            if (adv_ff >= SEQ_BITS'(WIN_LEN)) begin
               mem_req.clr_all = 1'b1;
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = IDX_W'(TOP_WORD);
               mem_req.wr_data = TOP_MASK;
               state_in        = S_DONE;
            end else begin
               mem_req.rd_en  = 1'b1;
               mem_req.rd_ptr = {1'b0, adv_word};
               rptr_in        = {1'b0, adv_word} + PTR_W'(1);
               shamt_in       = adv_ff[WORD_SHIFT-1:0];
               idx_in         = '0;
               state_in       = S_LOAD;
            end
         end
         S_LOAD: begin
            lo_in          = rd_word;
            mem_req.rd_en  = 1'b1;
            mem_req.rd_ptr = rptr_ff;
            rptr_in        = rptr_next;
            state_in       = S_SHIFT;
         end
         S_SHIFT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff;
            mem_req.wr_data = (idx_ff == IDX_W'(TOP_WORD)) ? (shifted | TOP_MASK) : shifted;
            lo_in           = rd_word;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_ptr  = rptr_ff;
            rptr_in         = rptr_next;
            idx_in          = idx_ff + IDX_W'(1);
            if (idx_ff == IDX_W'(WIN_WORDS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         base_ff   <= '0;
         replay_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         base_ff   <= base_in;
         replay_ff <= replay_in;
      end
      op_ff    <= op_in;
      seq_ff   <= seq_in;
      off_ff   <= off_in;
      adv_ff   <= adv_in;
      lo_ff    <= lo_in;
      shamt_ff <= shamt_in;
      idx_ff   <= idx_in;
      rptr_ff  <= rptr_in;
   end

`ifndef NO_ASSERTIONS
   a_no_same_word : assert property (@(posedge clock) disable iff (reset)
      mem_req.rd_en && mem_req.wr_en |-> mem_req.rd_ptr != {1'b0, mem_req.wr_addr})
      else $error("bitmap word read and written in the same cycle");

   a_read_ahead : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT |-> rptr_ff > {1'b0, idx_ff})
      else $error("shift pass read pointer fell behind the write index");

   a_base_moves_on_add : assert property (@(posedge clock) disable iff (reset)
      !$stable(base_ff) |-> $past(reset) || $past(state_ff == S_EVAL && op_ff == OP_ADD))
      else $error("window base changed outside an advancing add");
`endif

endmodule

@@ hdl/anti_replay_window.sv @@
`timescale 1ns / 1ps

// Sliding-window anti-replay check over 64-bit sequence numbers.
// Requests arrive on req_valid/req_ready with req_opcode (0 tests, 1 records)
// and req_seq_num; each transaction gives exactly one response transaction on
// rsp_valid/rsp_ready carrying rsp_is_replay (always 0 for a record).
// The look-ahead limit is written through csr_wr_en/csr_wr_data; the user
// must write it only while idle, the block does not enforce this. A
// transaction is worked on alone. A test outside the window passes S_EVAL and
// S_DONE, a test or a record inside it S_EVAL, S_LOOK and S_DONE, before the
// response is registered. A record beyond the window top reaches S_PREP,
// which clears the bitmap when it moves the window by the full length or more
// and otherwise starts a pass through S_LOAD and S_SHIFT that rewrites every
// bitmap word, before S_DONE. req_ready rises together with rsp_valid, so a
// new request is taken only once the last response is registered. A stalled
// receiver leaves one response in the output register and one more finished
// transaction inside the block before requests stop.
// Reset empties the window, sets the base to zero and the limit to 1024;
// the block takes requests in the first cycle after reset.
module anti_replay_window
   import ar_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_opcode,
   input  logic [SEQ_BITS-1:0]   req_seq_num,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_is_replay,
   input  logic                  csr_wr_en,
   input  logic [LIMIT_BITS-1:0] csr_wr_data
);

   logic [LIMIT_BITS-1:0] ahead_limit_ff, ahead_limit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_replay_ff, rsp_replay_in;
   logic                  out_free;
   result_type            result;
   mem_req_type           mem_req;
   logic [WORD_BITS-1:0]  rd_word;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      ahead_limit_in = csr_wr_en ? csr_wr_data : ahead_limit_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_replay_in  = rsp_replay_ff;
      if (result.done) begin
         rsp_valid_in  = 1'b1;
         rsp_replay_in = result.is_replay;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ahead_limit_ff <= AHEAD_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         ahead_limit_ff <= ahead_limit_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_replay_ff <= rsp_replay_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_is_replay = rsp_replay_ff;

   ar_seq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_seq_num (req_seq_num),
      .ahead_limit (ahead_limit_ff),
      .out_free    (out_free),
      .result      (result),
      .mem_req     (mem_req),
      .rd_word     (rd_word)
   );

   ar_bitmap_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_word (rd_word)
   );

endmodule
